// ===== src/sfd_pkg.sv =====
// Package for the framed payload deframer: frame stages, sync bytes and sizes.
// No dependencies; used by the interfaces and the top level.
package sfd_pkg;

    // Sync characters of the header and trailer.
    localparam logic [7:0] SYNC_CR = 8'h0D;
    localparam logic [7:0] SYNC_LF = 8'h0A;

    // Default payload length and the cap on words sent per frame.
    localparam int PAYLOAD_BYTES_DEF = 24;
    localparam int MAX_WORDS         = 6;

    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_word;
    typedef logic [2:0]  t_word_idx;

    // Frame stages.
    typedef enum logic [2:0] {
        ST_HUNT     = 3'd0,
        ST_GOT_CR   = 3'd1,
        ST_PAYLOAD  = 3'd2,
        ST_TRAIL_LF = 3'd3,
        ST_TRAIL_CR = 3'd4
    } t_stage;

endpackage

// ===== src/sfd_byte_if.sv =====
// Receive-byte channel: valid/ready handshake carrying one serial byte per beat.
// Depends on sfd_pkg.
interface sfd_byte_if;
    logic          valid;
    logic          ready;
    sfd_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/sfd_word_if.sv =====
// Payload-word channel: valid/ready handshake carrying one word, its index and last flag.
// Depends on sfd_pkg.
interface sfd_word_if;
    logic              valid;
    logic              ready;
    sfd_pkg::t_word     word_value;
    sfd_pkg::t_word_idx word_index;
    logic              last_word;

    modport source (output valid, output word_value, output word_index, output last_word,
                    input ready);
    modport sink   (input valid, input word_value, input word_index, input last_word,
                    output ready);
endinterface

// ===== src/sync_framed_payload_deframer.sv =====
// Top level of the CR LF synchronized fixed-length frame deframer.
// Depends on sfd_pkg, sfd_byte_if and sfd_word_if.
//
//   Channel   Direction  Beat payload
//   i_rx      in         rx_byte (8 bits)
//   o_word    out        word_value (32), word_index (3), last_word (1)
//
// One byte is taken per cycle while i_rx.ready is high; the stage register
// holds the new frame state in the cycle after. A closing CR starts a burst
// of min(PAYLOAD_BYTES/4, 6) words, one per cycle from the output register
// while the sink keeps ready high. Header bytes are still taken in a burst;
// a payload byte waits until r_busy falls, when the burst has left the store.
// Reset (i_rst_n low, synchronous) returns to the header hunt with no burst pending.
module sync_framed_payload_deframer #(
    parameter int PAYLOAD_BYTES = sfd_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfd_byte_if.sink    i_rx,
    sfd_word_if.source  o_word
);

    // Derived sizes: words sent per frame and bytes kept from the payload.
    localparam int NUM_WORDS = (PAYLOAD_BYTES / 4 > sfd_pkg::MAX_WORDS) ?
                               sfd_pkg::MAX_WORDS : PAYLOAD_BYTES / 4;
    localparam int KEEP_BYTES = NUM_WORDS * 4;
    localparam int POS_W      = $clog2(PAYLOAD_BYTES);
    localparam int WSEL_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

    sfd_pkg::t_stage    r_stage, n_stage;
    logic [POS_W-1:0]   r_pos, n_pos;
    sfd_pkg::t_word     r_store [NUM_WORDS];
    logic               r_busy;
    sfd_pkg::t_word_idx r_cnt;
    logic               r_out_valid;
    sfd_pkg::t_word     r_out_word;
    sfd_pkg::t_word_idx r_out_idx;
    logic               r_out_last;

    logic               w_rx_fire;
    logic               w_done;
    logic               w_store_we;
    logic               w_load;
    logic               w_cnt_last;
    logic [WSEL_W-1:0]  w_wr_word;

    // Payload bytes wait while a burst still reads the store.
    assign i_rx.ready = !(r_busy && (r_stage == sfd_pkg::ST_PAYLOAD));
    assign w_rx_fire  = i_rx.valid && i_rx.ready;

    // Frame stage and payload position, next values.
    always_comb begin
        n_stage    = r_stage;
        n_pos      = r_pos;
        w_done     = 1'b0;
        w_store_we = 1'b0;
        if (w_rx_fire) begin
            unique case (r_stage)
                sfd_pkg::ST_HUNT: begin
                    if (i_rx.rx_byte == sfd_pkg::SYNC_CR) begin
                        n_stage = sfd_pkg::ST_GOT_CR;
                    end
                end
                sfd_pkg::ST_GOT_CR: begin
                    if (i_rx.rx_byte == sfd_pkg::SYNC_LF) begin
                        n_pos   = '0;
                        n_stage = sfd_pkg::ST_PAYLOAD;
                    end else if (i_rx.rx_byte != sfd_pkg::SYNC_CR) begin
                        n_stage = sfd_pkg::ST_HUNT;
                    end
                end
                sfd_pkg::ST_PAYLOAD: begin
                    w_store_we = ({1'b0, r_pos} < (POS_W + 1)'(KEEP_BYTES));
                    if (r_pos == POS_W'(PAYLOAD_BYTES - 1)) begin
                        n_pos   = '0;
                        n_stage = sfd_pkg::ST_TRAIL_LF;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
                sfd_pkg::ST_TRAIL_LF: begin
                    n_stage = (i_rx.rx_byte == sfd_pkg::SYNC_LF) ?
                              sfd_pkg::ST_TRAIL_CR : sfd_pkg::ST_HUNT;
                end
                sfd_pkg::ST_TRAIL_CR: begin
                    w_done  = (i_rx.rx_byte == sfd_pkg::SYNC_CR);
                    n_stage = sfd_pkg::ST_HUNT;
                end
                default: begin
                    n_stage = sfd_pkg::ST_HUNT;
                end
            endcase
        end
    end

    // Stage and position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= sfd_pkg::ST_HUNT;
            r_pos   <= '0;
        end else begin
            r_stage <= n_stage;
            r_pos   <= n_pos;
        end
    end

    // Payload store, kept as little-endian words with a byte lane per position.
    assign w_wr_word = WSEL_W'(r_pos >> 2);

    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[w_wr_word][r_pos[1:0]*8 +: 8] <= i_rx.rx_byte;
        end
    end

    // Burst sequencer feeding the output register one word per beat.
    assign w_load     = r_busy && (!r_out_valid || o_word.ready);
    assign w_cnt_last = (r_cnt == 3'(NUM_WORDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_load) begin
                r_busy <= !w_cnt_last;
                r_cnt  <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_word.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word <= r_store[r_cnt[WSEL_W-1:0]];
            r_out_idx  <= r_cnt;
            r_out_last <= w_cnt_last;
        end
    end

    assign o_word.valid      = r_out_valid;
    assign o_word.word_value = r_out_word;
    assign o_word.word_index = r_out_idx;
    assign o_word.last_word  = r_out_last;

    // A payload byte is never taken while a burst still reads the store.
    a_no_write_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_stage == sfd_pkg::ST_PAYLOAD)) |-> !w_rx_fire)
        else $error("payload byte accepted during a word burst");

    // A completed frame always starts a burst.
    a_done_starts_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (r_busy && (r_cnt == '0)))
        else $error("completed frame did not start a burst");

    // The last flag marks exactly the final word index.
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> (o_word.last_word == (o_word.word_index == 3'(NUM_WORDS - 1))))
        else $error("last flag does not match the word index");

    // Reset leaves no word on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_word.valid)
        else $error("output valid after reset");

endmodule
